// ===== rtl/core/rc2_pkg.sv =====
// rc2 cbc cipher package: pi permutation, block/word packing and mix helpers, shared codes
// no dependencies
package rc2_pkg;

    localparam int KEY_WORDS  = 64;
    localparam int KEY_BYTES  = 128;
    localparam int KEY_LEN    = 8;
    localparam int ROUNDS     = 16;
    localparam int KW_AW      = 6;
    localparam int KB_AW      = 7;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef enum logic [0:0] {
        REG_KEY = 1'b0,
        REG_IV  = 1'b1
    } t_reg_addr;

    typedef enum logic [0:0] {
        FUNC_ENC = 1'b0,
        FUNC_DEC = 1'b1
    } t_func;

    function automatic logic [7:0] pi_lookup(input logic [7:0] idx);
        logic [7:0] tbl [0:255];
        tbl = '{
            8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
            8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
            8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
            8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
            8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
            8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
            8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
            8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
            8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
            8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
            8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
            8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
            8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
            8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
            8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
            8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
        };
        return tbl[idx];
    endfunction

    // little-endian word i from a block whose byte 0 sits in bits 63:56
    function automatic logic [15:0] blk_word(input logic [63:0] blk, input int i);
        return {blk[63-16*i-8 -: 8], blk[63-16*i -: 8]};
    endfunction

    function automatic logic [63:0] words_blk(input logic [15:0] w0, input logic [15:0] w1,
                                              input logic [15:0] w2, input logic [15:0] w3);
        return {w0[7:0], w0[15:8], w1[7:0], w1[15:8], w2[7:0], w2[15:8], w3[7:0], w3[15:8]};
    endfunction

    function automatic logic [15:0] mix_f(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
        return (a & b) + (~a & c);
    endfunction

endpackage

// ===== rtl/core/rc2_cbc_block_cipher.sv =====
// rc2 cbc block cipher top level: apb registers, cbc chaining, output register
// depends on rc2_pkg, rc2_keyexp, rc2_round
//
//  channel   direction  signals                              transfer when
//  input     in         i_func i_restart i_block_in          i_valid && o_ready
//  output    out        o_block_out                          o_valid && i_ready
//  config    in         psel penable pwrite paddr pwdata     psel && penable && pwrite
//
// a block runs 18 rounds of four word steps, each a key read, then a compute, one word
// at a time through the shared add/sub unit and its key-memory port
// the first block after a key write first runs the key schedule
// reset is synchronous active low; key memories are unset until expanded
// o_ready is low from acceptance until the result leaves the output register
module rc2_cbc_block_cipher
    import rc2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_restart,
    input  logic [63:0] i_block_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_block_out
);

    typedef enum logic [3:0] {
        TS_IDLE = 4'b0001,
        TS_KEY  = 4'b0010,
        TS_RUN  = 4'b0100,
        TS_OUT  = 4'b1000
    } t_top_state;

    t_top_state r_state;
    logic [63:0] r_key, r_iv, r_chain, r_blk, r_out;
    logic        r_key_ready, r_dec, r_kstart, r_rstart;
    logic        w_wr, w_in_xfer;
    logic        w_kbusy, w_kdone, w_kw_we, w_rdone;
    logic [KW_AW-1:0] w_kw_addr;
    logic [15:0] w_kw_data;
    logic [63:0] w_rblk, w_chain_use;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_IV) ? r_iv : r_key;
    assign o_ready = (r_state == TS_IDLE);
    assign o_valid = (r_state == TS_OUT);
    assign o_block_out = r_out;
    assign w_in_xfer = i_valid && o_ready;
    // restart takes the vector before this block
    assign w_chain_use = i_restart ? r_iv : r_chain;

    rc2_keyexp u_keyexp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kstart), .i_key(r_key),
        .o_busy(w_kbusy), .o_done(w_kdone), .o_kw_we(w_kw_we),
        .o_kw_addr(w_kw_addr), .o_kw_data(w_kw_data)
    );

    rc2_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_kw_we(w_kw_we), .i_kw_addr(w_kw_addr),
        .i_kw_data(w_kw_data), .i_start(r_rstart), .i_dec(r_dec),
        .i_blk(r_dec ? r_blk : (r_blk ^ r_chain)), .o_done(w_rdone), .o_blk(w_rblk)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_blk <= i_block_in;
            r_dec <= i_func;
        end
        if (w_rdone) begin
            // decrypt xors with the chain, then the chain becomes the ciphertext
            r_out <= r_dec ? (w_rblk ^ r_chain) : w_rblk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_key <= '0;
            r_iv <= '0;
            r_chain <= '0;
            r_key_ready <= 1'b0;
            r_kstart <= 1'b0;
            r_rstart <= 1'b0;
        end else begin
            r_kstart <= 1'b0;
            r_rstart <= 1'b0;
            if (w_wr && paddr[3] == REG_IV && paddr[2:0] == 3'd0) r_iv <= pwdata;
            if (w_wr && paddr[3] == REG_KEY && paddr[2:0] == 3'd0) begin
                r_key <= pwdata;
                r_key_ready <= 1'b0;
            end
            case (r_state)
                TS_IDLE: if (w_in_xfer) begin
                    r_chain <= w_chain_use;
                    if (r_key_ready) begin
                        r_state <= TS_RUN;
                        r_rstart <= 1'b1;
                    end else begin
                        r_state <= TS_KEY;
                        r_kstart <= 1'b1;
                    end
                end
                TS_KEY: if (w_kdone) begin
                    r_key_ready <= 1'b1;
                    r_state <= TS_RUN;
                    r_rstart <= 1'b1;
                end
                TS_RUN: if (w_rdone) begin
                    r_chain <= r_dec ? r_blk : w_rblk;
                    r_state <= TS_OUT;
                end
                TS_OUT: if (i_ready) r_state <= TS_IDLE;
                default: r_state <= TS_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_key_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_RUN) |-> !w_kbusy) else $error("key schedule busy while running");
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rdone |-> (r_state == TS_RUN)) else $error("round done outside run");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_block_out)) else $error("result changed");
`endif

endmodule

// ===== rtl/core/rc2_keyexp.sv =====
// rc2 key expansion sequencer: copies the key bytes, then one pi lookup per cycle into a byte memory,
// then packs byte pairs into the round-key memory; uses rc2_pkg
module rc2_keyexp
    import rc2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_key,
    output logic              o_busy,
    output logic              o_done,
    output logic              o_kw_we,
    output logic [KW_AW-1:0]  o_kw_addr,
    output logic [15:0]       o_kw_data
);

    typedef enum logic [4:0] {
        KS_IDLE = 5'b00001,
        KS_FWD  = 5'b00010,
        KS_MID  = 5'b00100,
        KS_BWD  = 5'b01000,
        KS_PACK = 5'b10000
    } t_ks_state;

    t_ks_state r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_prev, n_prev;     // byte produced in the previous cycle
    logic [7:0] r_mem [0:KEY_BYTES-1];
    logic [7:0] r_lo;
    logic [7:0] w_wr_val;
    logic       w_we;
    logic [KB_AW-1:0] w_wr_addr;
    logic [KB_AW-1:0] w_rd_addr;
    logic [7:0] r_rd;

    // forward: b[i] = pi(b[i-1] + b[i-8]); mid: pi(b[120]); back: pi(b[i+1] ^ b[i+8])
    // memory read is registered, so the address is issued in the previous cycle and read back via r_rd
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_prev = r_prev;
        w_we = 1'b0;
        w_wr_addr = r_cnt[KB_AW-1:0];
        w_wr_val = 8'h00;
        w_rd_addr = '0;
        o_kw_we = 1'b0;
        o_kw_addr = r_cnt[KW_AW:1];
        case (r_state)
            KS_IDLE: begin
                if (i_start) begin
                    n_state = KS_FWD;
                    n_cnt = 8'd0;
                end
            end
            KS_FWD: begin
                w_we = 1'b1;
                if (r_cnt < 8'(KEY_LEN)) begin
                    w_wr_val = i_key[63-8*r_cnt[2:0] -: 8];
                end else begin
                    w_wr_val = pi_lookup(r_prev + r_rd);
                end
                n_prev = w_wr_val;
                w_rd_addr = 7'(r_cnt + 8'd1 - 8'(KEY_LEN));
                if (r_cnt == 8'(KEY_BYTES - 1)) begin
                    n_state = KS_MID;
                    n_cnt = 8'(KEY_BYTES - KEY_LEN);
                    w_rd_addr = 7'(KEY_BYTES - KEY_LEN);
                end else begin
                    n_cnt = r_cnt + 8'd1;
                end
            end
            KS_MID: begin
                w_we = 1'b1;
                w_wr_val = pi_lookup(r_rd);
                n_prev = w_wr_val;
                n_cnt = 8'(KEY_BYTES - KEY_LEN - 1);
                w_rd_addr = 7'(KEY_BYTES - 1);
                n_state = KS_BWD;
            end
            KS_BWD: begin
                w_we = 1'b1;
                w_wr_val = pi_lookup(r_prev ^ r_rd);
                n_prev = w_wr_val;
                w_rd_addr = 7'(r_cnt + 8'(KEY_LEN) - 8'd1);
                if (r_cnt == 8'd0) begin
                    n_state = KS_PACK;
                    w_rd_addr = '0;
                end else begin
                    n_cnt = r_cnt - 8'd1;
                end
            end
            KS_PACK: begin
                // cnt is the read address; a pair is written on even cnt from 2
                w_rd_addr = r_cnt[KB_AW-1:0];
                o_kw_addr = 6'((r_cnt - 8'd2) >> 1);
                if (!r_cnt[0] && (r_cnt != 8'd0)) begin
                    o_kw_we = 1'b1;
                end
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'(KEY_BYTES)) begin
                    n_state = KS_IDLE;
                end
            end
            default: n_state = KS_IDLE;
        endcase
        o_kw_data = {r_rd, r_lo};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_val;
        end
        r_rd <= r_mem[w_rd_addr];
        r_lo <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_IDLE;
            r_cnt <= '0;
            r_prev <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_prev <= n_prev;
        end
    end

    // in pack, byte a sits in r_rd at cnt = a+1 and in r_lo at cnt = a+2
    assign o_busy = (r_state != KS_IDLE);
    assign o_done = (r_state == KS_PACK) && (r_cnt == 8'(KEY_BYTES));

endmodule

// ===== rtl/core/rc2_round.sv =====
// rc2 round datapath: one shared 16-bit add/sub unit, one word at a time,
// round-key memory with registered reads; uses rc2_pkg
module rc2_round
    import rc2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_kw_we,
    input  logic [KW_AW-1:0]  i_kw_addr,
    input  logic [15:0]       i_kw_data,
    input  logic              i_start,
    input  logic              i_dec,
    input  logic [63:0]       i_blk,
    output logic              o_done,
    output logic [63:0]       o_blk
);

    typedef enum logic [3:0] {
        RS_IDLE = 4'b0001,
        RS_ADDR = 4'b0010,
        RS_CALC = 4'b0100,
        RS_DONE = 4'b1000
    } t_rs_state;

    t_rs_state r_state, n_state;
    logic [15:0] r_w [0:3];
    logic [15:0] r_kmem [0:KEY_WORDS-1];
    logic [15:0] r_kd;
    logic [4:0]  r_round, n_round;  // 0..18, mash at 5 and 12
    logic [1:0]  r_wi, n_wi;
    logic [KW_AW-1:0] r_j, n_j;
    logic        r_dec;
    logic [KW_AW-1:0] w_kaddr;
    logic        w_mash;
    logic [1:0]  w_wsel;
    logic [15:0] w_x, w_rot, w_sum, w_res;
    logic [15:0] w_a, w_b, w_c;

    assign w_mash = (r_round == 5'd5) || (r_round == 5'd12);
    assign w_wsel = r_dec ? ~r_wi : r_wi;
    assign w_a = r_w[w_wsel + 2'd3];
    assign w_b = r_w[w_wsel + 2'd2];
    assign w_c = r_w[w_wsel + 2'd1];
    assign w_x = r_w[w_wsel];
    assign w_kaddr = w_mash ? w_a[KW_AW-1:0] : r_j;

    always_comb begin
        case (w_wsel)
            2'd0: w_rot = {w_x[0], w_x[15:1]};
            2'd1: w_rot = {w_x[1:0], w_x[15:2]};
            2'd2: w_rot = {w_x[2:0], w_x[15:3]};
            default: w_rot = {w_x[4:0], w_x[15:5]};
        endcase
        if (w_mash) begin
            w_sum = r_dec ? (w_x - r_kd) : (w_x + r_kd);
            w_res = w_sum;
        end else if (r_dec) begin
            w_sum = w_rot - r_kd - mix_f(w_a, w_b, w_c);
            w_res = w_sum;
        end else begin
            w_sum = w_x + r_kd + mix_f(w_a, w_b, w_c);
            case (w_wsel)
                2'd0: w_res = {w_sum[14:0], w_sum[15]};
                2'd1: w_res = {w_sum[13:0], w_sum[15:14]};
                2'd2: w_res = {w_sum[12:0], w_sum[15:13]};
                default: w_res = {w_sum[10:0], w_sum[15:11]};
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_wi = r_wi;
        n_j = r_j;
        case (r_state)
            RS_IDLE: if (i_start) begin
                n_state = RS_ADDR;
                n_round = '0;
                n_wi = '0;
                n_j = i_dec ? 6'(KEY_WORDS - 1) : '0;
            end
            RS_ADDR: n_state = RS_CALC;
            RS_CALC: begin
                n_wi = r_wi + 2'd1;
                n_state = RS_ADDR;
                if (!w_mash) begin
                    n_j = r_dec ? r_j - 6'd1 : r_j + 6'd1;
                end
                if (r_wi == 2'd3) begin
                    n_round = r_round + 5'd1;
                    if (r_round == 5'(ROUNDS + 1)) begin
                        n_state = RS_DONE;
                    end
                end
            end
            RS_DONE: n_state = RS_IDLE;
            default: n_state = RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_kw_we) begin
            r_kmem[i_kw_addr] <= i_kw_data;
        end
        r_kd <= r_kmem[w_kaddr];
        if (r_state == RS_IDLE && i_start) begin
            r_dec <= i_dec;
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= blk_word(i_blk, i);
            end
        end else if (r_state == RS_CALC) begin
            r_w[w_wsel] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_round <= '0;
            r_wi <= '0;
            r_j <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_wi <= n_wi;
            r_j <= n_j;
        end
    end

    assign o_done = (r_state == RS_DONE);
    assign o_blk = words_blk(r_w[0], r_w[1], r_w[2], r_w[3]);

endmodule
